// ----- hdl/drf_pkg.sv -----
// ----------------------------------------------------------------------------
// drf_pkg: shared types and codes for the diamond region fill block
// Holds the operation and register codes, the sequencer states and the
// row span record passed from the span unit to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package drf_pkg;

   // transaction operation codes
   localparam logic OP_PAINT = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT = 2'd1;

   // reset values of the map bounds
   localparam logic [5:0] MAP_WIDTH_RST  = 6'd32;
   localparam logic [5:0] MAP_HEIGHT_RST = 6'd32;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW,
      ST_SPAN,
      ST_READ
   } state_type;

   // clipped column span of one row, hi is exclusive
   typedef struct packed {
      logic       empty;
      logic [8:0] lo;
      logic [8:0] hi;
   } span_type;

endpackage

`default_nettype wire

// ----- hdl/drf_ram.sv -----
// ----------------------------------------------------------------------------
// drf_ram: generic single write, single read synchronous RAM
// One write port and one read port, read data registered.
// The read register holds its value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module drf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/drf_span.sv -----
// ----------------------------------------------------------------------------
// drf_span: row span unit
// For one row of a diamond, works out the half-width from the row distance
// and clips the column span to column zero and to the column limit.
// ----------------------------------------------------------------------------
`default_nettype none

module drf_span
   import drf_pkg::*;
(
   input  wire logic [7:0] row,
   input  wire logic [7:0] pos_x,
   input  wire logic [7:0] pos_y,
   input  wire logic [7:0] radius,
   input  wire logic [8:0] col_lim,
   output      span_type   span
);

   logic signed [9:0] row_diff;
   logic        [7:0] row_dist;
   logic        [7:0] half;
   logic signed [9:0] lo_raw;
   logic        [9:0] hi_raw;
   logic        [8:0] lo;
   logic        [8:0] hi;

   // distance of the row from the centre row
   always_comb begin
      row_diff = $signed({2'b00, row}) - $signed({2'b00, pos_y});
      row_dist = row_diff[9] ? 8'(-row_diff) : row_diff[7:0];
      half     = radius - row_dist;
   end

   // span ends, clipped on both sides
   always_comb begin
      lo_raw = $signed({2'b00, pos_x}) - $signed({2'b00, half});
      hi_raw = {2'b00, pos_x} + {2'b00, half} + 10'd1;
      lo     = lo_raw[9] ? 9'd0 : lo_raw[8:0];
      hi     = (hi_raw > {1'b0, col_lim}) ? col_lim : hi_raw[8:0];
   end

   assign span.lo    = lo;
   assign span.hi    = hi;
   assign span.empty = (lo >= hi);

endmodule

`default_nettype wire

// ----- hdl/diamond_region_fill_top.sv -----
// Read: cell held in the RAM read register, then offered once the output is free.
// Paint: after acceptance, each row visited, then each cell of its span written
//   (single write port of the cell memory); no result. One transaction at a time.
// A finished read result may wait in the output register while the next is taken.
// Reset: a clearing pass writes zero to all PLANE_WIDTH*PLANE_HEIGHT cells,
//   one per cycle, with req_ready low meanwhile.
// ----------------------------------------------------------------------------
// diamond_region_fill_top: byte plane with Manhattan diamond paint
// Paint writes a clipped diamond row by row into the cell memory; read
// returns one cell. Map bounds are set through the csr write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module diamond_region_fill_top
   import drf_pkg::*;
#(
   parameter int PLANE_WIDTH  = 32,
   parameter int PLANE_HEIGHT = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // transaction input
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic       req_op,
   input  wire logic [7:0] req_pos_x,
   input  wire logic [7:0] req_pos_y,
   input  wire logic [7:0] req_radius,
   input  wire logic [7:0] req_fill_value,
   // result output
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [7:0] rsp_cell_value,
   // register writes
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [5:0] csr_data
);

   localparam int DEPTH = PLANE_WIDTH * PLANE_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   state_type   state_ff, state_in;
   logic [5:0]  map_width_ff, map_width_in;
   logic [5:0]  map_height_ff, map_height_in;
   logic [7:0]  px_ff, px_in;
   logic [7:0]  py_ff, py_in;
   logic [7:0]  rad_ff, rad_in;
   logic [7:0]  val_ff, val_in;
   logic [7:0]  row_ff, row_in;
   logic [8:0]  rend_ff, rend_in;
   logic [8:0]  col_ff, col_in;
   logic [8:0]  hi_ff, hi_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic        oob_ff, oob_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;

   logic        req_fire;
   logic        rsp_free;
   logic [8:0]  col_lim;
   logic [8:0]  row_lim;
   logic [7:0]  rstart;
   logic [9:0]  rend_raw;
   logic [8:0]  rend;
   logic        read_in_plane;
   logic [8:0]  row_next;
   logic        row_last;
   logic        span_last;
   logic        clear_last;
   span_type    span;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [7:0]    mem_rd_data;

   // handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // map bounds, limited to the plane
   always_comb begin
      col_lim = ({3'b000, map_width_ff} > 9'(PLANE_WIDTH)) ?
                9'(PLANE_WIDTH) : {3'b000, map_width_ff};
      row_lim = ({3'b000, map_height_ff} > 9'(PLANE_HEIGHT)) ?
                9'(PLANE_HEIGHT) : {3'b000, map_height_ff};
   end

   // row range of a new paint, end exclusive
   always_comb begin
      rstart   = (req_pos_y >= req_radius) ? (req_pos_y - req_radius) : 8'd0;
      rend_raw = {2'b00, req_pos_y} + {2'b00, req_radius} + 10'd1;
      rend     = (rend_raw > {1'b0, row_lim}) ? row_lim : rend_raw[8:0];
      read_in_plane = ({1'b0, req_pos_x} < 9'(PLANE_WIDTH)) &&
                      ({1'b0, req_pos_y} < 9'(PLANE_HEIGHT));
   end

   // loop end checks
   always_comb begin
      row_next   = {1'b0, row_ff} + 9'd1;
      row_last   = (row_next >= rend_ff);
      span_last  = ((col_ff + 9'd1) >= hi_ff);
      clear_last = (addr_ff == AW'(DEPTH - 1));
   end

   drf_span u_span (
      .row     (row_ff),
      .pos_x   (px_ff),
      .pos_y   (py_ff),
      .radius  (rad_ff),
      .col_lim (col_lim),
      .span    (span)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_op == OP_READ) begin
                  state_in = ST_READ;
               end else if ({1'b0, rstart} < rend) begin
                  state_in = ST_ROW;
               end
            end
         end
         ST_ROW: begin
            if (!span.empty) begin
               state_in = ST_SPAN;
            end else if (row_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_SPAN: begin
            if (span_last) begin
               state_in = row_last ? ST_IDLE : ST_ROW;
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      rad_in        = rad_ff;
      val_in        = val_ff;
      row_in        = row_ff;
      rend_in       = rend_ff;
      col_in        = col_ff;
      hi_in         = hi_ff;
      addr_in       = addr_ff;
      oob_in        = oob_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = addr_ff;
      mem_wr_data   = val_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = AW'(int'(req_pos_y) * PLANE_WIDTH + int'(req_pos_x));

      // register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAP_WIDTH:  map_width_in  = csr_data;
            CSR_MAP_HEIGHT: map_height_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = 8'd0;
            addr_in     = addr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               px_in  = req_pos_x;
               py_in  = req_pos_y;
               rad_in = req_radius;
               val_in = req_fill_value;
               row_in = rstart;
               rend_in = rend;
               oob_in = !read_in_plane;
               mem_rd_en = (req_op == OP_READ) && read_in_plane;
            end
         end
         ST_ROW: begin
            col_in  = span.lo;
            hi_in   = span.hi;
            addr_in = AW'(int'(row_ff) * PLANE_WIDTH + int'(span.lo));
            if (span.empty && !row_last) begin
               row_in = row_next[7:0];
            end
         end
         ST_SPAN: begin
            mem_wr_en = 1'b1;
            col_in    = col_ff + 9'd1;
            addr_in   = addr_ff + AW'(1);
            if (span_last && !row_last) begin
               row_in = row_next[7:0];
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = oob_ff ? 8'd0 : mem_rd_data;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         map_width_ff  <= MAP_WIDTH_RST;
         map_height_ff <= MAP_HEIGHT_RST;
         rsp_valid_ff  <= 1'b0;
         addr_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
         rsp_valid_ff  <= rsp_valid_in;
         addr_ff       <= addr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      rad_ff      <= rad_in;
      val_ff      <= val_in;
      row_ff      <= row_in;
      rend_ff     <= rend_in;
      col_ff      <= col_in;
      hi_ff       <= hi_in;
      oob_ff      <= oob_in;
      rsp_data_ff <= rsp_data_in;
   end

   drf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_data_ff;

endmodule

`default_nettype wire
